// ----- hdl/ascii_hex_reading_parser_unit_assert.svh -----
// Assertion macros used by the checker file of the parser unit.
`ifndef ASCII_HEX_READING_PARSER_UNIT_ASSERT_SVH
`define ASCII_HEX_READING_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AHRP_ASSERT_IMPLY(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("ahrp assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AHRP_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("ahrp assertion failed");

`endif

// ----- hdl/ahrp_pkg.sv -----
// Shared constants and hex decode functions for the ASCII hex reading parser.
package ahrp_pkg;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 5;
    localparam int READ_W  = 16;
    localparam int SLOTS   = 8;
    localparam int SLOT_W  = 3;
    localparam int OUT_W   = 2 * READ_W;

    localparam logic [BYTE_W-1:0] CH_OPEN = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UPA  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPF  = 8'h46;

    localparam logic [POS_W-1:0] LEN_LIMIT = 5'd18;
    localparam logic [POS_W-1:0] POS_MAX   = 5'd31;

    // Bit 4 flags a bad character; bits 3:0 hold the digit value.
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] d;
        begin
            d = 8'h00;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                d = c - CH_ZERO;
                hex_digit = {1'b0, d[3:0]};
            end
            else if (c >= CH_UPA && c <= CH_UPF)
            begin
                d = c - CH_UPA + 8'd10;
                hex_digit = {1'b0, d[3:0]};
            end
            else
            begin
                hex_digit = 5'h10;
            end
        end
    endfunction

    // Two characters to one byte; any bad character zeroes the pair.
    function automatic logic [BYTE_W-1:0] hex_pair(input logic [BYTE_W-1:0] hi,
                                                   input logic [BYTE_W-1:0] lo);
        logic [4:0] a;
        logic [4:0] b;
        begin
            a = hex_digit(hi);
            b = hex_digit(lo);
            if (a[4] || b[4])
            begin
                hex_pair = 8'h00;
            end
            else
            begin
                hex_pair = {a[3:0], b[3:0]};
            end
        end
    endfunction

endpackage

// ----- hdl/ahrp_in_reg.sv -----
// Input register stage: holds one received byte until the parser takes it.
module ahrp_in_reg
    import ahrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
    input  logic              advance,
    output logic              item_valid,
    output logic [BYTE_W-1:0] item_byte
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

endmodule

// ----- hdl/ahrp_parser.sv -----
// Message state, kept characters and reading decode; one byte per cycle while fire is high.
module ahrp_parser
    import ahrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              emit,
    output logic [READ_W-1:0] scl_hundredths,
    output logic [READ_W-1:0] hrv_thousandths
);

    logic              in_message_reg;
    logic              in_message_next;
    logic [POS_W-1:0]  char_position_reg;
    logic [POS_W-1:0]  char_position_next;
    logic              nul_seen_reg;
    logic              nul_seen_next;
    logic [BYTE_W-1:0] field_chars_reg [SLOTS];

    logic              take;
    logic              store;
    logic              slot_hit;
    logic [SLOT_W-1:0] slot;

    // Only positions 5-8 and 10-13 are kept.
    always_comb
    begin
        slot_hit = 1'b1;
        slot     = 3'd0;
        case (char_position_reg)
            5'd5:    slot = 3'd0;
            5'd6:    slot = 3'd1;
            5'd7:    slot = 3'd2;
            5'd8:    slot = 3'd3;
            5'd10:   slot = 3'd4;
            5'd11:   slot = 3'd5;
            5'd12:   slot = 3'd6;
            5'd13:   slot = 3'd7;
            default: slot_hit = 1'b0;
        endcase
    end

    assign take  = fire && (in_message_reg || rx_byte == CH_OPEN);
    assign store = take && rx_byte != CH_CR && rx_byte != CH_LF
                   && char_position_reg < POS_MAX;
    assign emit  = take && rx_byte == CH_CR && !nul_seen_reg
                   && char_position_reg > LEN_LIMIT;

    assign scl_hundredths  = {hex_pair(field_chars_reg[0], field_chars_reg[1]),
                              hex_pair(field_chars_reg[2], field_chars_reg[3])};
    assign hrv_thousandths = {hex_pair(field_chars_reg[4], field_chars_reg[5]),
                              hex_pair(field_chars_reg[6], field_chars_reg[7])};

    always_comb
    begin
        in_message_next    = in_message_reg;
        char_position_next = char_position_reg;
        nul_seen_next      = nul_seen_reg;
        if (take)
        begin
            if (rx_byte == CH_CR)
            begin
                // Close the message and wait for the next opener.
                in_message_next    = 1'b0;
                char_position_next = '0;
                nul_seen_next      = 1'b0;
            end
            else
            begin
                in_message_next = 1'b1;
                if (store)
                begin
                    char_position_next = char_position_reg + 5'd1;
                    if (rx_byte == CH_NUL && char_position_reg <= LEN_LIMIT)
                    begin
                        nul_seen_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_message_reg    <= 1'b0;
            char_position_reg <= '0;
            nul_seen_reg      <= 1'b0;
        end
        else
        begin
            in_message_reg    <= in_message_next;
            char_position_reg <= char_position_next;
            nul_seen_reg      <= nul_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store && slot_hit)
        begin
            field_chars_reg[slot] <= rx_byte;
        end
    end

endmodule

// ----- hdl/ascii_hex_reading_parser_unit.sv -----
// Top level of the ASCII hex reading parser: input stage, parser, result register.
//
// Slave stream (s_tvalid/s_tready/s_tdata) carries one received byte per beat.
// Bytes before a '<' are dropped; inside a message every byte but CR and LF is
// counted, and the characters at positions 5-8 and 10-13 are kept. A CR ends
// the message; if no NUL came within the first 19 positions and at least 19
// bytes were counted, one result beat goes out on the master stream with the
// two decoded 16-bit readings.
// A CR beat is held in the input register, parsed, and its result is captured
// in the result register before it goes out on the master stream.
// Throughput: one byte per cycle while the sink does not stall, set by the
// input register feeding the combinational parse and result register.
// When the sink stalls with a result waiting, the input register holds one
// more byte, then s_tready drops until the result beat is taken.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to waiting for '<'; kept characters are not cleared.
module ascii_hex_reading_parser_unit
    import ahrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // [15:0] scl_hundredths, [31:16] hrv_thousandths
);

    logic              item_valid;
    logic [BYTE_W-1:0] item_byte;
    logic              fire;
    logic              emit;
    logic [READ_W-1:0] scl;
    logic [READ_W-1:0] hrv;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [OUT_W-1:0]  out_data_reg;

    // Parse the held byte whenever the result register can take a new beat.
    assign fire = item_valid && (!out_valid_reg || m_tready);

    ahrp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (fire),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    ahrp_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .rx_byte         (item_byte),
        .emit            (emit),
        .scl_hundredths  (scl),
        .hrv_thousandths (hrv)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= {hrv, scl};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- hdl/ahrp_checker.sv -----
// Port-level checker for the parser unit and its bind to the top level.
`include "ascii_hex_reading_parser_unit_assert.svh"

module ahrp_checker
    import ahrp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [BYTE_W-1:0] s_tdata,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata
);

    `AHRP_ASSERT_NEXT(a_out_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `AHRP_ASSERT_NEXT(a_out_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
    // Input back-pressure only comes from a stalled result beat.
    `AHRP_ASSERT_IMPLY(a_stall_cause, !s_tready, m_tvalid && !m_tready)
    // A fresh result follows a CR beat taken by the input register and then parsed.
    `AHRP_ASSERT_IMPLY(a_result_after_cr, $rose(m_tvalid),
                       $past(s_tvalid && s_tready && s_tdata == CH_CR, 2))

endmodule

bind ascii_hex_reading_parser_unit ahrp_checker u_ahrp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
